// File: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the sorted list table
// Transaction structs, operation and status codes, default capacity.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int SLT_CAPACITY = 16;
  localparam int VALUE_W      = 32;
  localparam int MODE_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int ENTRY_CNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } slt_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [ENTRY_CNT_W-1:0] entry_count;
  } slt_out_t;

  // Strobes broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;
    logic ins_go;
    logic del_go;
  } slt_cell_ctl_t;

endpackage

// File: rtl/core/sorted_list_table_top.sv
// ----------------------------------------------------------------------------
// sorted_list_table_top: bounded table of signed values in ascending order
//
// Input channel in_valid/in_ready/in_data carries one transaction: a mode
// (insert, search, delete) and a signed 32-bit value. Output channel
// out_valid/out_ready/out_data returns exactly one result per transaction:
// a status (done or found, table full, not found) and the entry count after
// the operation.
//
// Storage is a row of CAPACITY cells. In the cycle a transaction is
// accepted, every cell compares its entry with the value and registers
// its flags; once the result register is free, the hit flags are
// OR-reduced and the cells shift together, inserting or removing one
// entry. The result register loads with that shift, and a new
// transaction is accepted only after the previous one has resolved.
//
// Reset clears the entry count and out_valid; entries need no
// clearing. When the receiver stalls, one more transaction is accepted and
// compared, then held until the result register frees up.
// ----------------------------------------------------------------------------
module sorted_list_table_top
  import slt_pkg::*;
#(
  parameter int CAPACITY = SLT_CAPACITY
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  slt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output slt_out_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]          count;
  logic signed [VALUE_W-1:0] cell_value;
  slt_cell_ctl_t             ctl;
  logic                      found;

  logic signed [VALUE_W-1:0] entry_vec [CAPACITY];
  logic [CAPACITY-1:0]       occ_vec;
  logic [CAPACITY-1:0]       geq_vec;
  logic [CAPACITY-1:0]       match_vec;

  assign found = |match_vec;

  slt_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .found      (found),
    .count      (count),
    .cell_value (cell_value),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                      left_occ;
    logic                      left_geq;
    logic signed [VALUE_W-1:0] left_entry;
    logic signed [VALUE_W-1:0] right_entry;

    assign occ_vec[i] = (CNT_W'(i) < count);

    if (i == 0) begin : g_head
      assign left_occ   = 1'b1;
      assign left_geq   = 1'b0;
      assign left_entry = entry_vec[i];
    end else begin : g_body
      assign left_occ   = occ_vec[i-1];
      assign left_geq   = geq_vec[i-1];
      assign left_entry = entry_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entry_vec[i];
    end else begin : g_inner
      assign right_entry = entry_vec[i+1];
    end

    slt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (cell_value),
      .occ         (occ_vec[i]),
      .left_occ    (left_occ),
      .left_geq    (left_geq),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entry_vec[i]),
      .geq         (geq_vec[i]),
      .match       (match_vec[i])
    );
  end

endmodule

// File: rtl/core/slt_cell.sv
// ----------------------------------------------------------------------------
// slt_cell: one position of the sorted list table
// Holds one entry, compares it with the transaction value and shifts
// toward either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module slt_cell
  import slt_pkg::*;
(
  input  logic                      clk,
  input  slt_cell_ctl_t             ctl,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                      occ,
  input  logic                      left_occ,
  input  logic                      left_geq,
  input  logic signed [VALUE_W-1:0] left_entry,
  input  logic signed [VALUE_W-1:0] right_entry,
  output logic signed [VALUE_W-1:0] entry,
  output logic                      geq,
  output logic                      match
);

  logic at_count;

  // first free position: this cell empty, left neighbor occupied
  assign at_count = !occ && left_occ;

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      geq   <= occ && !(entry < value);
      match <= occ && (entry == value);
    end
    if (ctl.ins_go) begin
      if (left_geq) begin
        entry <= left_entry;
      end else if (geq || at_count) begin
        entry <= value;
      end
    end else if (ctl.del_go) begin
      // every cell from the first match onward pulls from the right
      if (geq) begin
        entry <= right_entry;
      end
    end
  end

endmodule

// File: rtl/core/slt_ctrl.sv
// ----------------------------------------------------------------------------
// slt_ctrl: sequencer of the sorted list table
// Latches the input transaction, keeps the entry count, issues the cell
// strobes and holds the result register.
// ----------------------------------------------------------------------------
module slt_ctrl
  import slt_pkg::*;
#(
  parameter int CAPACITY = SLT_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  slt_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output slt_out_t                  out_data,
  input  logic                      found,
  output logic [CNT_W-1:0]          count,
  output logic signed [VALUE_W-1:0] cell_value,
  output slt_cell_ctl_t             ctl
);

  typedef enum logic {
    S_IDLE,
    S_RESOLVE
  } state_t;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  state_t              state;
  slt_in_t             op;
  logic                fire;
  logic                full;
  logic [STATUS_W-1:0] status_next;
  logic [CNT_W-1:0]    count_next;

  assign in_ready   = (state == S_IDLE);
  assign fire       = (state == S_RESOLVE) && (!out_valid || out_ready);
  assign full       = (count >= CAP_CNT);
  assign cell_value = (state == S_IDLE) ? in_data.value : op.value;

  assign ctl.cmp_en = in_valid && in_ready;
  assign ctl.ins_go = fire && (op.mode == MODE_INSERT) && !full;
  assign ctl.del_go = fire && (op.mode == MODE_DELETE) && found;

  always_comb begin
    status_next = STATUS_OK;
    count_next  = count;
    unique case (op.mode)
      MODE_INSERT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      MODE_SEARCH: begin
        if (!found) begin
          status_next = STATUS_MISSING;
        end
      end
      MODE_DELETE: begin
        if (found) begin
          count_next = count - CNT_W'(1);
        end else begin
          status_next = STATUS_MISSING;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_data;
            state <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          // hold until the result register is free
          if (fire) begin
            count                <= count_next;
            out_valid            <= 1'b1;
            out_data.status      <= status_next;
            out_data.entry_count <= ENTRY_CNT_W'(count_next);
            state                <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_list_table_top
// A queue of insert, search, delete and unused-mode transactions drives the input channel
// with random gaps; a local copy of the ordered table predicts each result,
// and the output monitor compares status and entry count field by field.
// ----------------------------------------------------------------------------
module testbench;
  import slt_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int N_RANDOM   = 1650;
  localparam int POOL_SIZE  = 20;
  localparam int QUIET_TAIL = 150;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  slt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  slt_out_t out_data;

  sorted_list_table_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  slt_in_t  pending_ops[$];
  slt_out_t expected_results[$];

  // Local copy of the ordered table
  logic signed [VALUE_W-1:0] tbl [SLT_CAPACITY];
  int tbl_cnt = 0;

  int n_err = 0;
  int n_results = 0;
  int n_accepted = 0;
  int n_ins = 0, n_srch = 0, n_del = 0, n_unused = 0;
  int n_full = 0, n_miss = 0, peak_cnt = 0;
  logic [3:0]  in_gap = '0;
  logic [3:0]  out_gap = '0;
  logic [15:0] cyc = '0;
  logic        quiet;
  slt_out_t    exp_r;

  logic signed [VALUE_W-1:0] pool [POOL_SIZE];

  assign quiet = (pending_ops.size() < QUIET_TAIL);

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Work out the result of one accepted transaction and update the table
  task automatic apply_op(input slt_in_t t);
    int p;
    int hit;
    slt_out_t r;
    r.status = STATUS_OK;
    hit = -1;
    for (int i = 0; i < tbl_cnt; i++) begin
      if (hit < 0 && tbl[i] == t.value) hit = i;
    end
    case (t.mode)
      MODE_INSERT: begin
        n_ins++;
        if (tbl_cnt >= SLT_CAPACITY) begin
          r.status = STATUS_FULL;
          n_full++;
        end else begin
          p = 0;
          while (p < tbl_cnt && tbl[p] < t.value) p++;
          for (int i = tbl_cnt; i > p; i--) tbl[i] = tbl[i-1];
          tbl[p] = t.value;
          tbl_cnt++;
        end
      end
      MODE_SEARCH: begin
        n_srch++;
        if (hit < 0) begin
          r.status = STATUS_MISSING;
          n_miss++;
        end
      end
      MODE_DELETE: begin
        n_del++;
        if (hit < 0) begin
          r.status = STATUS_MISSING;
          n_miss++;
        end else begin
          for (int i = hit; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
          tbl_cnt--;
        end
      end
      default: begin
        n_unused++;
      end
    endcase
    if (tbl_cnt > peak_cnt) peak_cnt = tbl_cnt;
    r.entry_count = ENTRY_CNT_W'(tbl_cnt);
    expected_results.push_back(r);
  endtask

  function automatic slt_in_t make_op(input logic [MODE_W-1:0] m,
                                      input logic signed [VALUE_W-1:0] v);
    slt_in_t t;
    t.mode  = m;
    t.value = v;
    return t;
  endfunction

  task automatic flag_error(input string msg);
    n_err++;
    if (n_err <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Stimulus
  initial begin
    int r;
    logic [MODE_W-1:0] m;
    logic signed [VALUE_W-1:0] v;
    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = 0;
    pool[3] = -1;
    pool[4] = 1;
    for (int i = 5; i < POOL_SIZE; i++) pool[i] = $urandom;

    // Extremes, duplicates, hits and misses
    pending_ops.push_back(make_op(MODE_INSERT, 32'sh8000_0000));
    pending_ops.push_back(make_op(MODE_INSERT, 32'sh7fff_ffff));
    pending_ops.push_back(make_op(MODE_INSERT, 0));
    pending_ops.push_back(make_op(MODE_INSERT, -1));
    pending_ops.push_back(make_op(MODE_INSERT, 0));
    pending_ops.push_back(make_op(MODE_SEARCH, 0));
    pending_ops.push_back(make_op(MODE_SEARCH, 1));
    pending_ops.push_back(make_op(MODE_UNUSED, 32'sh7fff_ffff));
    pending_ops.push_back(make_op(MODE_DELETE, 7));
    // Fill to capacity, then overflow
    for (int k = 0; k < 11; k++) pending_ops.push_back(make_op(MODE_INSERT, 300 * k - 1500));
    pending_ops.push_back(make_op(MODE_INSERT, 5));
    pending_ops.push_back(make_op(MODE_SEARCH, 32'sh8000_0000));
    // Remove head, then tail
    pending_ops.push_back(make_op(MODE_DELETE, 32'sh8000_0000));
    pending_ops.push_back(make_op(MODE_DELETE, 32'sh7fff_ffff));

    // Alternate fill-biased and drain-biased stretches so occupancy sweeps
    for (int n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (((n / 48) % 2) == 0) begin
        m = (r < 60) ? MODE_INSERT : (r < 75) ? MODE_SEARCH :
            (r < 95) ? MODE_DELETE : MODE_UNUSED;
      end else begin
        m = (r < 25) ? MODE_INSERT : (r < 45) ? MODE_SEARCH :
            (r < 95) ? MODE_DELETE : MODE_UNUSED;
      end
      if ($urandom_range(0, 3) == 0) v = $urandom;
      else v = pool[$urandom_range(0, POOL_SIZE - 1)];
      pending_ops.push_back(make_op(m, v));
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1'b1;
  end

  // Input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        apply_op(in_data);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1'b1;
        end else if (pending_ops.size() > 0) begin
          in_data  <= pending_ops.pop_front();
          in_valid <= 1'b1;
          if (!quiet && !cyc[8] && $urandom_range(0, 5) == 0)
            in_gap <= 4'($urandom_range(1, 7));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result status=%0d count=%0d",
                               out_data.status, out_data.entry_count));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_data.status !== exp_r.status)
            flag_error($sformatf("result %0d status: expected %0d, got %0d",
                                 n_results, exp_r.status, out_data.status));
          if (out_data.entry_count !== exp_r.entry_count)
            flag_error($sformatf("result %0d entry_count: expected %0d, got %0d",
                                 n_results, exp_r.entry_count, out_data.entry_count));
        end
      end
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap   <= out_gap - 1'b1;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && !cyc[9] && $urandom_range(0, 7) == 0)
          out_gap <= 4'($urandom_range(1, 7));
      end
    end
  end

  // End of run
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (pending_ops.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Covered %0d transactions: %0d inserts, %0d searches, %0d deletes, %0d unused mode",
             n_accepted, n_ins, n_srch, n_del, n_unused);
    $display("Full rejects %0d, not-found results %0d, peak occupancy %0d, mismatches %0d",
             n_full, n_miss, peak_cnt, n_err);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
rtl/core/slt_pkg.sv
rtl/core/slt_cell.sv
rtl/core/slt_ctrl.sv
rtl/core/sorted_list_table_top.sv
verif/testbench.sv
